### rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, widths and the microcode program of the prime range counter.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int BOUND_BITS         = 16;
    localparam int COUNT_BITS         = 13;
    localparam int VALUE_BITS_DEFAULT = 16;
    localparam int STEP_BITS          = 5;

    typedef logic [STEP_BITS-1:0] step_t;

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LOAD_FIVE,
        OP_MOD_START,
        OP_MOD_STEP,
        OP_ADD_TWO_START,
        OP_ADD_FOUR,
        OP_COUNT,
        OP_NEXT_CAND,
        OP_DELIVER
    } op_t;

    // Jump conditions; a true condition loads the target, else the step advances
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_LE_ONE,
        C_LE_THREE,
        C_EVEN,
        C_MUL_THREE,
        C_MOD_BUSY,
        C_REM_ZERO,
        C_SQ_GT,
        C_LAST,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    localparam step_t S_IDLE       = 5'd0;
    localparam step_t S_CHK_ONE    = 5'd1;
    localparam step_t S_CHK_THREE  = 5'd2;
    localparam step_t S_CHK_TWO    = 5'd3;
    localparam step_t S_CHK_DIV3   = 5'd4;
    localparam step_t S_LOOP       = 5'd5;
    localparam step_t S_LOW_START  = 5'd6;
    localparam step_t S_LOW_MOD    = 5'd7;
    localparam step_t S_LOW_REM    = 5'd8;
    localparam step_t S_HIGH_START = 5'd9;
    localparam step_t S_HIGH_MOD   = 5'd10;
    localparam step_t S_HIGH_REM   = 5'd11;
    localparam step_t S_ADVANCE    = 5'd12;
    localparam step_t S_PRIME      = 5'd13;
    localparam step_t S_NEXT       = 5'd14;
    localparam step_t S_INC        = 5'd15;
    localparam step_t S_DONE       = 5'd16;
    localparam step_t S_WAIT       = 5'd17;

    function automatic ctrl_t ucode(input step_t step);
        ctrl_t w;
        begin
            unique case (step)
                S_IDLE:       w = '{OP_ACCEPT,        C_NO_INPUT,  S_IDLE};
                S_CHK_ONE:    w = '{OP_NONE,          C_LE_ONE,    S_NEXT};
                S_CHK_THREE:  w = '{OP_NONE,          C_LE_THREE,  S_PRIME};
                S_CHK_TWO:    w = '{OP_NONE,          C_EVEN,      S_NEXT};
                S_CHK_DIV3:   w = '{OP_LOAD_FIVE,     C_MUL_THREE, S_NEXT};
                S_LOOP:       w = '{OP_NONE,          C_SQ_GT,     S_PRIME};
                S_LOW_START:  w = '{OP_MOD_START,     C_NEVER,     S_IDLE};
                S_LOW_MOD:    w = '{OP_MOD_STEP,      C_MOD_BUSY,  S_LOW_MOD};
                S_LOW_REM:    w = '{OP_NONE,          C_REM_ZERO,  S_NEXT};
                S_HIGH_START: w = '{OP_ADD_TWO_START, C_NEVER,     S_IDLE};
                S_HIGH_MOD:   w = '{OP_MOD_STEP,      C_MOD_BUSY,  S_HIGH_MOD};
                S_HIGH_REM:   w = '{OP_NONE,          C_REM_ZERO,  S_NEXT};
                S_ADVANCE:    w = '{OP_ADD_FOUR,      C_ALWAYS,    S_LOOP};
                S_PRIME:      w = '{OP_COUNT,         C_NEVER,     S_IDLE};
                S_NEXT:       w = '{OP_NONE,          C_LAST,      S_DONE};
                S_INC:        w = '{OP_NEXT_CAND,     C_ALWAYS,    S_CHK_ONE};
                S_DONE:       w = '{OP_DELIVER,       C_OUT_FREE,  S_IDLE};
                S_WAIT:       w = '{OP_NONE,          C_ALWAYS,    S_DONE};
                default:      w = '{OP_NONE,          C_ALWAYS,    S_IDLE};
            endcase
            return w;
        end
    endfunction

    // Base-4 digits sum to the same residue mod 3 as the whole value
    function automatic logic is_mult_three(input logic [BOUND_BITS-1:0] v);
        logic [5:0] s1;
        logic [3:0] s2;
        begin
            s1 = '0;
            for (int i = 0; i < BOUND_BITS; i += 2)
                s1 = s1 + 6'(v[i +: 2]);
            s2 = 4'(s1[1:0]) + 4'(s1[3:2]) + 4'(s1[5:4]);
            return (s2 == 4'd0) || (s2 == 4'd3) || (s2 == 4'd6) || (s2 == 4'd9);
        end
    endfunction

endpackage

### rtl/prc_query_if.sv
// ----------------------------------------------------------------------------
// prc_query_if
// Query channel: two range bounds with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface prc_query_if
    import prc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [BOUND_BITS-1:0] range_start;
    logic [BOUND_BITS-1:0] range_end;

    modport source (output valid, output range_start, output range_end, input ready);
    modport sink   (input valid, input range_start, input range_end, output ready);
endinterface

### rtl/prc_result_if.sv
// ----------------------------------------------------------------------------
// prc_result_if
// Result channel: prime count with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface prc_result_if
    import prc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] prime_count;

    modport source (output valid, output prime_count, input ready);
    modport sink   (input valid, input prime_count, output ready);
endinterface

### rtl/prime_range_counter.sv
// ----------------------------------------------------------------------------
// prime_range_counter
// Counts the primes in a closed range by trial division under microcode.
// ----------------------------------------------------------------------------
// The block takes one query of two bounds (swapped if given in reverse order,
// each masked to VALUE_BITS bits) and returns the number of primes between
// them, inclusive. It works on one query at a time: query.ready is high only
// while the sequencer sits in its idle step. Every candidate above 3 in the
// range is screened for factors 2 and 3; the divisors 6k-1, 6k+1 run on a
// single bit-serial remainder unit, each divisor taking a start step, W
// shift steps and a remainder check, W = min(VALUE_BITS, 16). A candidate
// of 0 or 1 is rejected at once, 2 and 3 are counted as primes, an even
// candidate or an odd multiple of 3 is rejected by the screens, and any
// other is tried against each pair of divisors 6k-1, 6k+1 up to its square
// root, a factor ending the walk early. The count of a query waits until
// the output register is free to take it.
// The result waits in an output register until result.ready takes it.
// ----------------------------------------------------------------------------
module prime_range_counter
    import prc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    prc_query_if.sink     query,
    prc_result_if.source  result
);

    localparam int CW   = (VALUE_BITS < BOUND_BITS) ? VALUE_BITS : BOUND_BITS;
    localparam int DW   = (CW + 1) / 2 + 2;
    localparam int CNTW = $clog2(CW + 1);
    localparam int IW   = $clog2(CW);

    step_t                 step_reg, step_next;
    logic [CW-1:0]         hi_reg, hi_next;
    logic [CW-1:0]         cand_reg, cand_next;
    logic [DW-1:0]         div_reg, div_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [CNTW-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [COUNT_BITS-1:0] out_count_reg, out_count_next;
    logic                  out_valid_reg, out_valid_next;

    ctrl_t                 ctrl;
    logic                  cond_true;
    logic                  out_free;
    logic [CW-1:0]         in_a;
    logic [CW-1:0]         in_b;
    logic [BOUND_BITS-1:0] cand_ext;
    logic [2*DW-1:0]       div_sq;
    logic [IW-1:0]         bit_idx;
    logic [DW:0]           shifted;
    logic [DW:0]           diff;

    assign ctrl     = ucode(step_reg);
    assign out_free = !out_valid_reg || result.ready;
    assign in_a     = query.range_start[CW-1:0];
    assign in_b     = query.range_end[CW-1:0];
    assign cand_ext = BOUND_BITS'(cand_reg);
    assign div_sq   = div_reg * div_reg;

    // Bit-serial remainder: shift in the candidate from its top bit
    assign bit_idx  = IW'(bit_cnt_reg - 1'b1);
    assign shifted  = {rem_reg, cand_reg[bit_idx]};
    assign diff     = shifted - {1'b0, div_reg};

    assign query.ready        = (step_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.prime_count = out_count_reg;

    always_comb
    begin
        unique case (ctrl.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_NO_INPUT:  cond_true = !query.valid;
            C_LE_ONE:    cond_true = (cand_reg <= CW'(1));
            C_LE_THREE:  cond_true = (cand_reg <= CW'(3));
            C_EVEN:      cond_true = !cand_reg[0];
            C_MUL_THREE: cond_true = is_mult_three(cand_ext);
            C_MOD_BUSY:  cond_true = (bit_cnt_reg != CNTW'(1));
            C_REM_ZERO:  cond_true = (rem_reg == '0);
            C_SQ_GT:     cond_true = (div_sq > (2*DW)'(cand_reg));
            C_LAST:      cond_true = (cand_reg == hi_reg);
            C_OUT_FREE:  cond_true = out_free;
            default:     cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        step_next      = cond_true ? ctrl.target : step_t'(step_reg + 1'b1);
        hi_next        = hi_reg;
        cand_next      = cand_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        bit_cnt_next   = bit_cnt_reg;
        count_next     = count_reg;
        out_count_next = out_count_reg;
        out_valid_next = out_valid_reg && !result.ready;

        unique case (ctrl.op)
            OP_NONE:
            begin
            end
            OP_ACCEPT:
            begin
                if (query.valid)
                begin
                    // Swap reversed bounds; the walk starts at the lower one
                    if (in_a > in_b)
                    begin
                        cand_next = in_b;
                        hi_next   = in_a;
                    end
                    else
                    begin
                        cand_next = in_a;
                        hi_next   = in_b;
                    end
                    count_next = '0;
                end
            end
            OP_LOAD_FIVE:
            begin
                div_next = DW'(5);
            end
            OP_MOD_START:
            begin
                rem_next     = '0;
                bit_cnt_next = CNTW'(CW);
            end
            OP_MOD_STEP:
            begin
                rem_next     = diff[DW] ? shifted[DW-1:0] : diff[DW-1:0];
                bit_cnt_next = bit_cnt_reg - 1'b1;
            end
            OP_ADD_TWO_START:
            begin
                div_next     = div_reg + DW'(2);
                rem_next     = '0;
                bit_cnt_next = CNTW'(CW);
            end
            OP_ADD_FOUR:
            begin
                div_next = div_reg + DW'(4);
            end
            OP_COUNT:
            begin
                count_next = count_reg + 1'b1;
            end
            OP_NEXT_CAND:
            begin
                cand_next = cand_reg + 1'b1;
            end
            OP_DELIVER:
            begin
                if (out_free)
                begin
                    out_count_next = count_reg;
                    out_valid_next = 1'b1;
                    div_next       = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= S_IDLE;
            out_valid_reg <= 1'b0;
            cand_reg      <= '0;
            div_reg       <= '0;
            count_reg     <= '0;
            bit_cnt_reg   <= '0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            cand_reg      <= cand_next;
            div_reg       <= div_next;
            count_reg     <= count_next;
            bit_cnt_reg   <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg        <= hi_next;
        rem_reg       <= rem_next;
        out_count_reg <= out_count_next;
    end

endmodule
